/* hw/rtl/lfr_pkg.sv */
// Shared types and constants for the LRU frame replacer.
`default_nettype none

package lfr_pkg;

    // Number of frames tracked, and the widths of a frame number and a count.
    localparam int FRAMES  = 64;
    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    // Action codes of an input word.
    typedef enum logic [1:0] {
        ACT_VICTIM = 2'd0,
        ACT_PIN    = 2'd1,
        ACT_UNPIN  = 2'd2
    } t_action;

    // One slot of the recency order.
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] id;
    } t_slot;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               do_unpin;
        logic               do_pin;
        logic               do_victim;
        logic [FRAME_W-1:0] key;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* hw/rtl/lru_frame_replacer_unit.sv */
// Top level of the LRU frame replacer: handshakes, membership flags, count and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_action, i_frame_num
//  out     | output    | o_out_valid / i_out_ready  | o_found, o_victim_frame, o_entry_count
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (capacity)
//
// Each accepted word updates the whole cell row at that edge, and the
// result is shown from the output register in the next cycle, one word per cycle sustained while results are taken.
// The longest path is the match-and-shift ripple through the 64 cells on a pin.
// Input stalls only while the output register is full and not being taken.
// Reset is synchronous; there is no clearing pass, the block is ready right after it.
`default_nettype none

module lru_frame_replacer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [lfr_pkg::FRAME_W-1:0] i_frame_num,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [lfr_pkg::FRAME_W-1:0] o_victim_frame,
    output logic [lfr_pkg::COUNT_W-1:0] o_entry_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lfr_pkg::COUNT_W-1:0] i_cfg_data
);
    import lfr_pkg::*;

    logic [COUNT_W-1:0] r_capacity;
    logic [FRAMES-1:0]  r_member;
    logic [FRAMES-1:0]  n_member;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;
    logic               r_found;
    logic [FRAME_W-1:0] r_victim;
    logic [COUNT_W-1:0] r_entry;

    logic               accept;
    t_action            action;
    t_cell_cmd          cmd;
    logic [FRAME_W-1:0] oldest;

    // Handshakes.
    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign accept      = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign action      = t_action'(i_action);

    // Decode the word into a cell command; ignored actions give no command.
    always_comb begin
        cmd     = '{do_unpin: 1'b0, do_pin: 1'b0, do_victim: 1'b0, key: i_frame_num};
        if (accept) begin
            case (action)
                ACT_VICTIM: cmd.do_victim = (r_count != '0);
                ACT_PIN:    cmd.do_pin    = r_member[i_frame_num];
                ACT_UNPIN:  cmd.do_unpin  = ~r_member[i_frame_num]
                                            && (r_count < r_capacity)
                                            && (r_count < COUNT_W'(FRAMES));
                default:    cmd.do_victim = 1'b0;
            endcase
        end
    end

    lfr_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_oldest (oldest)
    );

    // Membership flags and entry count follow the command.
    always_comb begin
        n_member = r_member;
        n_count  = r_count;
        if (cmd.do_unpin) begin
            n_member[i_frame_num] = 1'b1;
            n_count               = r_count + 1'b1;
        end else if (cmd.do_pin) begin
            n_member[i_frame_num] = 1'b0;
            n_count               = r_count - 1'b1;
        end else if (cmd.do_victim) begin
            n_member[oldest]      = 1'b0;
            n_count               = r_count - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= COUNT_W'(FRAMES);
            r_member    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            r_member <= n_member;
            r_count  <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found  <= cmd.do_victim;
            r_victim <= cmd.do_victim ? oldest : '0;
            r_entry  <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_victim_frame = r_victim;
    assign o_entry_count  = r_entry;

`ifndef SYNTH
    // The count always equals the number of member frames.
    a_count_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == COUNT_W'($countones(r_member)))
        else $error("entry count does not match membership flags");

    // The set never exceeds the frame table.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(FRAMES))
        else $error("entry count exceeds frame table");

    // A victim request on a non-empty set reports a found frame.
    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_action == ACT_VICTIM) && (r_count != '0) |=> o_out_valid && o_found)
        else $error("victim on non-empty set reported not found");
`endif

endmodule

`default_nettype wire

/* hw/rtl/lfr_cell.sv */
// One slot cell of the recency chain: holds a frame and moves it to a neighbor.
`default_nettype none

module lfr_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfr_pkg::t_cell_cmd i_cmd,
    input  lfr_pkg::t_slot    i_left,
    input  lfr_pkg::t_slot    i_right,
    input  logic              i_kill,
    output logic              o_kill,
    output lfr_pkg::t_slot    o_slot,
    output logic              o_last
);
    import lfr_pkg::*;

    logic               r_valid;
    logic [FRAME_W-1:0] r_id;
    logic               n_valid;
    logic [FRAME_W-1:0] n_id;
    logic               match;

    // A pinned frame starts a left shift through its own cell and all older cells after it.
    assign match  = r_valid && (r_id == i_cmd.key);
    assign o_kill = i_kill | match;
    assign o_last = r_valid & ~i_right.valid;
    assign o_slot = '{valid: r_valid, id: r_id};

    // Next slot contents for each command.
    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        if (i_cmd.do_unpin) begin
            n_valid = i_left.valid;
            n_id    = i_left.id;
        end else if (i_cmd.do_pin && o_kill) begin
            n_valid = i_right.valid;
            n_id    = i_right.id;
        end else if (i_cmd.do_victim && o_last) begin
            n_valid = 1'b0;
        end
    end

    // Valid bit is control state; the frame number needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule

`default_nettype wire

/* hw/rtl/lfr_chain.sv */
// Row of slot cells, newest frame in cell 0, with the oldest-frame readout.
`default_nettype none

module lfr_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfr_pkg::t_cell_cmd          i_cmd,
    output logic [lfr_pkg::FRAME_W-1:0] o_oldest
);
    import lfr_pkg::*;

    t_slot              slot   [FRAMES];
    t_slot              left   [FRAMES];
    t_slot              right  [FRAMES];
    logic [FRAMES:0]    kill;
    logic [FRAMES-1:0]  last;

    assign kill[0] = 1'b0;

    // Cell 0 takes the new frame on unpin; the last cell pulls in an empty slot on pin.
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left[g] = '{valid: 1'b1, id: i_cmd.key};
        end else begin : g_mid_l
            assign left[g] = slot[g-1];
        end
        if (g == FRAMES - 1) begin : g_tail
            assign right[g] = '{valid: 1'b0, id: '0};
        end else begin : g_mid_r
            assign right[g] = slot[g+1];
        end

        lfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_left  (left[g]),
            .i_right (right[g]),
            .i_kill  (kill[g]),
            .o_kill  (kill[g+1]),
            .o_slot  (slot[g]),
            .o_last  (last[g])
        );
    end

    // At most one cell is the last valid one, so an OR over the row selects it.
    always_comb begin
        o_oldest = '0;
        for (int i = 0; i < FRAMES; i++) begin
            o_oldest = o_oldest | (slot[i].id & {FRAME_W{last[i]}});
        end
    end

endmodule

`default_nettype wire
